FILE: design/vmc_pkg.sv
// types, codes and helpers shared by the ventilation mode controller
`timescale 1ns / 1ps

package vmc_pkg;

    localparam int UV_GROUPS   = 3;
    localparam int PCT_W       = 7;
    localparam int SECS_W      = 16;
    localparam int UV_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 4;
    localparam int M_TDATA_W   = 24;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_CLEAN = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_CAL   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        KIND_TICK      = 4'd0,
        KIND_START     = 4'd1,
        KIND_START_UV  = 4'd2,
        KIND_CALIBRATE = 4'd3,
        KIND_STOP      = 4'd4,
        KIND_UV_ON     = 4'd5,
        KIND_UV_OFF    = 4'd6,
        KIND_EMERGENCY = 4'd7,
        KIND_TOGGLE    = 4'd8,
        KIND_SENSORS   = 4'd9,
        KIND_SPEED     = 4'd10
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CLEAN  = 2'd0,
        REG_FINISH_CLEAN = 2'd1,
        REG_TOP_FAN      = 2'd2
    } cfg_reg_t;

    // fan enable bits
    localparam int EN_EXTRACT = 0;
    localparam int EN_SUPPLY  = 1;
    localparam int EN_GAS     = 2;

    typedef struct packed {
        logic [1:0]       uv_group_for_speed;
        logic             fatal_alarm;
        logic [PCT_W-1:0] speed_req;
        logic [3:0]       kind;
    } item_t;

    typedef struct packed {
        logic             alarm_latched;
        logic             uv_enabled;
        logic [UV_W-1:0]  uv_mask;
        logic             gas_on;
        logic             supply_fan_on;
        logic             extract_fan_on;
        logic [PCT_W-1:0] fan_percent;
        logic [1:0]       fan_mode;
    } result_t;

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    // single lit group, none for group 0 or a group that does not exist
    function automatic logic [UV_W-1:0] uv_bits(input logic [1:0] group);
        logic [UV_W-1:0] bits;
        bits = '0;
        if (group != 2'd0 && int'(group) <= UV_GROUPS) begin
            bits = UV_W'(1) << (group - 2'd1);
        end
        return bits;
    endfunction

endpackage

FILE: design/vmc_seq.sv
// mode sequencer state, configuration registers and per-word update logic
`timescale 1ns / 1ps

module vmc_seq
    import vmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [SECS_W-1:0]    cfg_wdata,
    input  logic                 fire,
    input  item_t                item,
    output result_t              result
);

    logic [SECS_W-1:0] start_secs_reg;
    logic [SECS_W-1:0] finish_secs_reg;
    logic [PCT_W-1:0]  top_pct_reg;

    mode_t             mode_reg,      mode_next;
    logic              auto_uv_reg,   auto_uv_next;
    logic              stop_ac_reg,   stop_ac_next;
    logic [SECS_W-1:0] remain_reg,    remain_next;
    logic              timer_reg,     timer_next;
    logic              uv_on_reg,     uv_on_next;
    logic [PCT_W-1:0]  drive_reg,     drive_next;
    logic [2:0]        enables_reg,   enables_next;
    logic [UV_W-1:0]   uv_lit_reg,    uv_lit_next;
    logic              alarm_reg,     alarm_next;

    logic              enter;
    mode_t             enter_mode;
    logic [SECS_W-1:0] enter_period;
    logic [PCT_W-1:0]  speed;
    logic [UV_W-1:0]   group_bits;
    logic              start_kind;

    assign speed      = sat_pct(item.speed_req);
    assign group_bits = uv_bits(item.uv_group_for_speed);
    assign start_kind = (item.kind == KIND_START) || (item.kind == KIND_START_UV)
                        || (item.kind == KIND_CALIBRATE);

    always_comb begin
        mode_next    = mode_reg;
        auto_uv_next = auto_uv_reg;
        stop_ac_next = stop_ac_reg;
        remain_next  = remain_reg;
        timer_next   = timer_reg;
        uv_on_next   = uv_on_reg;
        drive_next   = drive_reg;
        enables_next = enables_reg;
        uv_lit_next  = uv_lit_reg;
        alarm_next   = alarm_reg;
        enter        = 1'b0;
        enter_mode   = MODE_OFF;
        enter_period = '0;

        if (item.kind == KIND_TICK) begin
            if (timer_reg) begin
                if (remain_reg <= SECS_W'(1)) begin
                    remain_next = '0;
                    timer_next  = 1'b0;
                    // expiry only acts while cleaning
                    if (mode_reg == MODE_CLEAN) begin
                        if (auto_uv_reg) begin
                            auto_uv_next = 1'b0;
                            uv_on_next   = 1'b1;
                            uv_lit_next  = group_bits;
                        end
                        enter      = 1'b1;
                        enter_mode = stop_ac_reg ? MODE_OFF : MODE_RUN;
                    end
                end else begin
                    remain_next = remain_reg - SECS_W'(1);
                end
            end
        end else begin
            unique case (mode_reg)
                MODE_OFF: begin
                    if (start_kind) begin
                        if (item.fatal_alarm) begin
                            alarm_next = 1'b1;
                        end else if (item.kind == KIND_CALIBRATE) begin
                            enter      = 1'b1;
                            enter_mode = MODE_CAL;
                        end else begin
                            auto_uv_next = (item.kind == KIND_START_UV);
                            stop_ac_next = 1'b0;
                            enter        = 1'b1;
                            enter_mode   = MODE_CLEAN;
                            enter_period = start_secs_reg;
                        end
                    end
                end
                MODE_CLEAN: begin
                    if (item.kind == KIND_UV_ON) begin
                        auto_uv_next = 1'b1;
                    end else if (item.kind == KIND_EMERGENCY) begin
                        enter      = 1'b1;
                        enter_mode = MODE_OFF;
                    end else if (item.kind == KIND_TOGGLE) begin
                        timer_next = 1'b0;
                        enter      = 1'b1;
                        enter_mode = stop_ac_reg ? MODE_RUN : MODE_OFF;
                    end
                end
                MODE_RUN: begin
                    if (item.kind == KIND_STOP) begin
                        stop_ac_next = 1'b1;
                        enter        = 1'b1;
                        enter_mode   = MODE_CLEAN;
                        enter_period = finish_secs_reg;
                    end else if (item.kind == KIND_UV_ON) begin
                        if (uv_on_reg) uv_lit_next = group_bits;
                    end else if (item.kind == KIND_UV_OFF) begin
                        uv_lit_next = '0;
                    end else if (item.kind == KIND_EMERGENCY) begin
                        enter      = 1'b1;
                        enter_mode = MODE_OFF;
                    end else if (item.kind == KIND_SENSORS) begin
                        drive_next = speed;
                    end else if (item.kind == KIND_SPEED) begin
                        drive_next = speed;
                        if (uv_on_reg) uv_lit_next = group_bits;
                    end
                end
                MODE_CAL: begin
                    if (item.kind == KIND_STOP || item.kind == KIND_EMERGENCY) begin
                        enter      = 1'b1;
                        enter_mode = MODE_OFF;
                    end else if (item.kind == KIND_SPEED) begin
                        drive_next = speed;
                        if (uv_on_reg) uv_lit_next = group_bits;
                    end
                end
                default: begin
                end
            endcase
        end

        // mode entry overrides what the event itself changed
        if (enter) begin
            mode_next = enter_mode;
            unique case (enter_mode)
                MODE_OFF: begin
                    enables_next = '0;
                    uv_on_next   = 1'b0;
                    uv_lit_next  = '0;
                end
                MODE_CLEAN: begin
                    remain_next = enter_period;
                    timer_next  = 1'b1;
                    if (enter_period != '0) begin
                        drive_next   = sat_pct(top_pct_reg);
                        enables_next = enables_next | 3'b011;
                    end
                end
                MODE_RUN: begin
                    drive_next   = speed;
                    enables_next = 3'b111;
                end
                MODE_CAL: begin
                    drive_next   = '0;
                    enables_next = 3'b011;
                    uv_on_next   = 1'b0;
                    uv_lit_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        result.fan_mode       = mode_next;
        result.fan_percent    = drive_next;
        result.extract_fan_on = enables_next[EN_EXTRACT];
        result.supply_fan_on  = enables_next[EN_SUPPLY];
        result.gas_on         = enables_next[EN_GAS];
        result.uv_mask        = uv_lit_next;
        result.uv_enabled     = uv_on_next;
        result.alarm_latched  = alarm_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_secs_reg  <= '0;
            finish_secs_reg <= '0;
            top_pct_reg     <= PCT_MAX;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_START_CLEAN:  start_secs_reg  <= cfg_wdata;
                REG_FINISH_CLEAN: finish_secs_reg <= cfg_wdata;
                REG_TOP_FAN:      top_pct_reg     <= cfg_wdata[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OFF;
            auto_uv_reg <= 1'b0;
            stop_ac_reg <= 1'b0;
            remain_reg  <= '0;
            timer_reg   <= 1'b0;
            uv_on_reg   <= 1'b0;
            drive_reg   <= '0;
            enables_reg <= '0;
            uv_lit_reg  <= '0;
            alarm_reg   <= 1'b0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            auto_uv_reg <= auto_uv_next;
            stop_ac_reg <= stop_ac_next;
            remain_reg  <= remain_next;
            timer_reg   <= timer_next;
            uv_on_reg   <= uv_on_next;
            drive_reg   <= drive_next;
            enables_reg <= enables_next;
            uv_lit_reg  <= uv_lit_next;
            alarm_reg   <= alarm_next;
        end
    end

endmodule

FILE: design/ventilation_mode_controller.sv
// top level of the ventilation mode controller: stream ports, input and result registers
`timescale 1ns / 1ps

// Mode sequencer of an air-handling unit (off, cleaning, running, calibration).
// Each input word is one event, a tick word counting one second of the cleaning
// period; each word gives exactly one result word holding the state after it.
// Words pass through an input register, combinational update logic and a result
// register, so the block takes one word per cycle unless a result waits untaken
// on the master side; the result word is offered there once the input register
// has passed it to the result register. Configuration writes are always taken
// (cfg_ready is tied high) and are meant only while idle.

module ventilation_mode_controller
    import vmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SECS_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // speed_req[6:0], fatal_alarm[7], uv_group_for_speed[9:8], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[3:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fan_mode[1:0], fan_percent[8:2], extract_fan_on[9], supply_fan_on[10],
    // gas_on[11], uv_mask[14:12], uv_enabled[15], alarm_latched[16], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t res_comb;
    item_t   s_item;
    logic    advance;
    logic    fire;
    logic    s_accept;
    logic    m_accept;

    assign cfg_ready = 1'b1;

    assign s_item.kind               = s_tuser;
    assign s_item.speed_req          = s_tdata[6:0];
    assign s_item.fatal_alarm        = s_tdata[7];
    assign s_item.uv_group_for_speed = s_tdata[9:8];

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;

    vmc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .fire      (fire),
        .item      (in_item_reg),
        .result    (res_comb)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_accept) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) in_item_reg <= s_item;
        if (fire)     res_reg     <= res_comb;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, res_reg};

    // the sticky alarm survives every later word
    a_alarm_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.alarm_latched |=> res_reg.alarm_latched)
        else $error("alarm flag dropped");

    // off means every fan and the gas class are disabled and no uv lit
    a_off_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.fan_mode == MODE_OFF |->
        !res_reg.extract_fan_on && !res_reg.supply_fan_on && !res_reg.gas_on
        && res_reg.uv_mask == '0 && !res_reg.uv_enabled)
        else $error("outputs active while off");

    // calibration keeps both fans on with gas and uv off
    a_cal_outputs: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.fan_mode == MODE_CAL |->
        res_reg.extract_fan_on && res_reg.supply_fan_on && !res_reg.gas_on
        && res_reg.uv_mask == '0)
        else $error("calibration outputs wrong");

    a_uv_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0(res_reg.uv_mask) && res_reg.fan_percent <= PCT_MAX)
        else $error("uv mask or drive out of range");

    // a result leaves only when taken or replaced by the next one
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule
